@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the cache modules.
// Each macro expects a clock named clk and an active-low reset named rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DMRC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DMRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dmrc_pkg.sv @@
// ---------------------------------------------------------------------------
// dmrc_pkg
// Geometry, payload types and controller interface of the read cache.
// ---------------------------------------------------------------------------
package dmrc_pkg;

    localparam int LINE_BYTES = 16;
    localparam int NUM_LINES  = 8;
    localparam int MEM_BYTES  = 4096;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int IDX_W  = $clog2(NUM_LINES);
    localparam int BLK_W  = ADDR_W - OFF_W;
    localparam int TAG_W  = BLK_W - IDX_W;
    localparam int LADDR_W = IDX_W + OFF_W;

    localparam int BYTE_W = 8;
    localparam int MISS_W = 16;
    localparam int TIME_W = 32;

    localparam logic [BYTE_W-1:0] MISS_PENALTY_RST = 8'd20;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] load_byte;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] read_byte;
        logic [TAG_W-1:0]  tag_part;
        logic [IDX_W-1:0]  line_index;
        logic [OFF_W-1:0]  word_offset;
        logic [BLK_W-1:0]  block_number;
        logic [MISS_W-1:0] misses_so_far;
        logic [TIME_W-1:0] elapsed_time;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic preload;
        logic lookup;
        logic fill_rd;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_read;
        logic hit;
        logic fill_last;
    } dp_sts_t;

endpackage

@@ sv/dmrc_datapath.sv @@
// ---------------------------------------------------------------------------
// dmrc_datapath
// Backing memory, line storage, tags, counters and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dmrc_datapath
    import dmrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_sts_t           sts,
    input  req_t              in_data,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_data,
    output rsp_t              out_data
);

    logic [BYTE_W-1:0] backing_mem [MEM_BYTES];
    logic [BYTE_W-1:0] line_mem [NUM_LINES * LINE_BYTES];
    logic [TAG_W-1:0]  tag_mem [NUM_LINES];

    logic [NUM_LINES-1:0] line_valid_reg;
    req_t                 req_reg;
    logic [BYTE_W-1:0]    miss_penalty_reg;
    logic [MISS_W-1:0]    miss_cnt_reg;
    logic [MISS_W-1:0]    miss_cnt_next;
    logic [TIME_W-1:0]    time_reg;
    logic [TIME_W-1:0]    time_next;
    logic [OFF_W-1:0]     fill_cnt_reg;
    logic [OFF_W-1:0]     fill_cnt_next;
    logic                 fill_wr_reg;
    logic [OFF_W-1:0]     fill_wr_idx_reg;
    logic [BYTE_W-1:0]    mem_q_reg;
    logic [BYTE_W-1:0]    line_q_reg;
    logic                 hit_reg;
    rsp_t                 out_data_reg;

    logic [OFF_W-1:0] word_off;
    logic [IDX_W-1:0] line_idx;
    logic [TAG_W-1:0] tag;
    logic [BLK_W-1:0] blk;
    logic             hit;
    logic [TIME_W:0]  time_sum;

    assign word_off = req_reg.address[OFF_W-1:0];
    assign line_idx = req_reg.address[OFF_W +: IDX_W];
    assign tag      = req_reg.address[ADDR_W-1 -: TAG_W];
    assign blk      = req_reg.address[ADDR_W-1:OFF_W];

    assign hit = line_valid_reg[line_idx] && (tag_mem[line_idx] == tag);

    assign sts.req_read  = in_data.req_type;
    assign sts.hit       = hit;
    assign sts.fill_last = (fill_cnt_reg == OFF_W'(LINE_BYTES - 1));

    // The time sum is one bit wider so that saturation can be detected.
    always_comb
    begin
        time_sum = {1'b0, time_reg} + (TIME_W + 1)'(1);
        if (!hit)
        begin
            time_sum = time_sum + (TIME_W + 1)'(miss_penalty_reg);
        end
        time_next = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];

        miss_cnt_next = miss_cnt_reg;
        if (!hit && (miss_cnt_reg != {MISS_W{1'b1}}))
        begin
            miss_cnt_next = miss_cnt_reg + MISS_W'(1);
        end

        fill_cnt_next = fill_cnt_reg;
        if (cmd.lookup)
        begin
            fill_cnt_next = '0;
        end
        else if (cmd.fill_rd)
        begin
            fill_cnt_next = fill_cnt_reg + OFF_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg   <= '0;
            miss_penalty_reg <= MISS_PENALTY_RST;
            miss_cnt_reg     <= '0;
            time_reg         <= '0;
            fill_cnt_reg     <= '0;
            fill_wr_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                miss_penalty_reg <= cfg_data;
            end
            if (cmd.lookup)
            begin
                miss_cnt_reg <= miss_cnt_next;
                time_reg     <= time_next;
                if (!hit)
                begin
                    line_valid_reg[line_idx] <= 1'b1;
                end
            end
            fill_cnt_reg <= fill_cnt_next;
            fill_wr_reg  <= cmd.fill_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_data;
        end
        if (cmd.lookup)
        begin
            hit_reg <= hit;
            if (!hit)
            begin
                tag_mem[line_idx] <= tag;
            end
        end
        if (cmd.fill_rd)
        begin
            fill_wr_idx_reg <= fill_cnt_reg;
        end
        if (cmd.out_load)
        begin
            out_data_reg.hit           <= hit_reg;
            out_data_reg.read_byte     <= line_q_reg;
            out_data_reg.tag_part      <= tag;
            out_data_reg.line_index    <= line_idx;
            out_data_reg.word_offset   <= word_off;
            out_data_reg.block_number  <= blk;
            out_data_reg.misses_so_far <= miss_cnt_reg;
            out_data_reg.elapsed_time  <= time_reg;
        end
    end

    // Backing memory: preload writes, one fill read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.preload)
        begin
            backing_mem[in_data.address] <= in_data.load_byte;
        end
        if (cmd.fill_rd)
        begin
            mem_q_reg <= backing_mem[{blk, fill_cnt_reg}];
        end
    end

    // Line storage: each fill write lands in the cycle after its backing read.
    always_ff @(posedge clk)
    begin
        if (fill_wr_reg)
        begin
            line_mem[{line_idx, fill_wr_idx_reg}] <= mem_q_reg;
        end
        line_q_reg <= line_mem[{line_idx, word_off}];
    end

    assign out_data = out_data_reg;

    `DMRC_ASSERT_NEXT(dp_miss_count_monotonic, 1'b1, miss_cnt_reg >= $past(miss_cnt_reg),
        "miss counter went down")
    `DMRC_ASSERT_NEXT(dp_time_advances, cmd.lookup,
        (time_reg != $past(time_reg)) || (time_reg == {TIME_W{1'b1}}),
        "time counter did not advance on a read")
    `DMRC_ASSERT_NEXT(dp_line_valid_after_lookup, cmd.lookup, line_valid_reg[line_idx],
        "line not valid after lookup")

endmodule

@@ sv/dmrc_ctrl.sv @@
// ---------------------------------------------------------------------------
// dmrc_ctrl
// Sequencer for lookup, line fill and result transfer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dmrc_ctrl
    import dmrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FILL,
        ST_DRAIN,
        ST_SETTLE,
        ST_RESPOND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.preload = !sts.req_read;
                    if (sts.req_read)
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = sts.hit ? ST_RESPOND : ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill_rd = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SETTLE;
            end
            ST_SETTLE:
            begin
                // The line read now sees the byte written by the last fill write.
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `DMRC_ASSERT_NEXT(ctrl_fill_ends, (state_reg == ST_FILL) && sts.fill_last,
        state_reg == ST_DRAIN, "fill did not end after the last byte")
    `DMRC_ASSERT_NEXT(ctrl_hit_skips_fill, (state_reg == ST_LOOKUP) && sts.hit,
        state_reg == ST_RESPOND, "hit did not go straight to the result")
    `DMRC_ASSERT(ctrl_result_from_respond, $rose(out_valid_reg),
        $past(state_reg) == ST_RESPOND, "result raised outside the respond state")

endmodule

@@ sv/direct_mapped_read_cache_core.sv @@
// ---------------------------------------------------------------------------
// direct_mapped_read_cache_core
// Read-only direct-mapped cache, 8 lines of 16 bytes, over 4 KiB of memory.
// ---------------------------------------------------------------------------
// Items are handled one at a time. A preload transfer writes one byte of
// backing memory in the cycle it is accepted and produces no result. A read
// that hits passes through the lookup state and then loads the result
// register in the respond state. A read that misses is looked up, then the
// 16-byte line is filled through the single read port of the backing memory
// at one byte per cycle, then the fill pipeline is drained, the line is
// re-read and the result is loaded. The input stays stalled until the result
// is loaded, and stays stalled longer when an earlier result is still held
// by out_stall. The result register lets the next item be accepted while a
// finished result still waits on out_stall.
// There is no clearing pass after reset; miss_penalty resets to 20 and is
// written through cfg_we.
// ---------------------------------------------------------------------------
module direct_mapped_read_cache_core
    import dmrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  req_t              in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rsp_t              out_data,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    dmrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    dmrc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

endmodule
